// ===== src/swstat_pkg.sv =====
// shared constants and types for the sliding window statistics block
package swstat_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int SUM_W       = 22;
    localparam int SQ_W        = 38;
    localparam int SSQ_W       = 32;
    localparam int PRODA_W     = 45;
    localparam int PRODB_W     = 44;
    localparam int NUM_W       = 43;
    localparam int MEAN_W      = 24;
    localparam int VAR_W       = 40;
    localparam int MED_W       = 17;
    localparam int MDVD_W      = 30;
    localparam int DIVD_W      = 51;
    localparam int DIVS_W      = 12;
    localparam int DCNT_W      = 6;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CNT_W-1:0]  DEFAULT_WINDOW = 7'd50;
    localparam logic [CNT_W-1:0]  MAX_LEN        = 7'd64;
    localparam logic [DCNT_W-1:0] MEAN_STEPS     = 6'd30;
    localparam logic [DCNT_W-1:0] VAR_STEPS      = 6'd51;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic take;
        logic ring_step;
        logic update;
        logic mul;
        logic div_mean;
        logic div_var;
        logic load_mean;
        logic load_var;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic func_clear;
        logic div_busy;
        logic sort_busy;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== src/sliding_window_statistics.sv =====
// an add runs through setup states (sample take, ring step, sum update, products), the
// shared bit-serial divider for mean and then variance, and a final result transfer;
// the sorted-copy merge pass runs alongside the divisions.
// a clear goes straight to the result transfer. one item is in flight at a time.
// reset: window length 50, window empty, no clearing pass; the result register may
// still hold a finished result while the next item is already transferred in.
module sliding_window_statistics (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      func,
    input  logic signed [swstat_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [swstat_pkg::MEAN_W-1:0]      mean_q8,
    output logic [swstat_pkg::VAR_W-1:0]              variance_q8,
    output logic signed [swstat_pkg::MED_W-1:0]       median_x2,
    output logic [swstat_pkg::CNT_W-1:0]              fill_count,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [swstat_pkg::ADDR_W-1:0]             paddr,
    input  logic [swstat_pkg::DATA_W-1:0]             pwdata,
    output logic [swstat_pkg::DATA_W-1:0]             prdata,
    output logic                                      pready
);

    swstat_pkg::dp_cmd_t cmd;
    swstat_pkg::dp_sts_t sts;

    assign pready = 1'b1;

    swstat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swstat_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .sample      (sample),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean_q8     (mean_q8),
        .variance_q8 (variance_q8),
        .median_x2   (median_x2),
        .fill_count  (fill_count)
    );

endmodule

// ===== src/swstat_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module swstat_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             long_op,
    input  logic [swstat_pkg::DIVD_W-1:0]    dividend,
    input  logic [swstat_pkg::DIVS_W-1:0]    divisor,
    output logic                             busy,
    output logic [swstat_pkg::DIVD_W-1:0]    quotient
);

    logic                            busy_reg;
    logic [swstat_pkg::DCNT_W-1:0]   cnt_reg;
    logic [swstat_pkg::DIVS_W-1:0]   rem_reg;
    logic [swstat_pkg::DIVS_W-1:0]   dsr_reg;
    logic [swstat_pkg::DIVD_W-1:0]   quo_reg;
    logic [swstat_pkg::DIVS_W:0]     trial;
    logic                            ge;

    assign trial = {rem_reg, quo_reg[swstat_pkg::DIVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= long_op ? swstat_pkg::VAR_STEPS : swstat_pkg::MEAN_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            // short operands are moved to the top so the first step sees their msb
            if (long_op)
            begin
                quo_reg <= dividend;
            end
            else
            begin
                quo_reg <= {dividend[swstat_pkg::MDVD_W-1:0],
                            {(swstat_pkg::DIVD_W-swstat_pkg::MDVD_W){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 12'(trial - {1'b0, dsr_reg}) : trial[swstat_pkg::DIVS_W-1:0];
            quo_reg <= {quo_reg[swstat_pkg::DIVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/swstat_sort.sv =====
// sorted copy of the window, rebuilt by a merge pass between two banks
module swstat_sort (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [swstat_pkg::SAMPLE_BITS-1:0] new_val,
    input  logic signed [swstat_pkg::SAMPLE_BITS-1:0] old_val,
    input  logic                                  full,
    input  logic [swstat_pkg::CNT_W-1:0]          count,
    output logic                                  busy,
    output logic signed [swstat_pkg::MED_W-1:0]   median_x2
);

    logic signed [swstat_pkg::SAMPLE_BITS-1:0] bank0 [swstat_pkg::MAX_WINDOW];
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] bank1 [swstat_pkg::MAX_WINDOW];

    logic                                      busy_reg;
    logic                                      prime_reg;
    logic                                      sel_reg;
    logic                                      ins_reg;
    logic                                      rem_reg;
    logic [swstat_pkg::CNT_W-1:0]              head_reg;
    logic [swstat_pkg::CNT_W-1:0]              wr_reg;
    logic [swstat_pkg::CNT_W-1:0]              cnt_reg;
    logic [swstat_pkg::CNT_W-1:0]              ncnt_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] new_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] old_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] q_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] lo_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] hi_reg;

    logic                                      active;
    logic                                      head_ok;
    logic                                      skip;
    logic                                      put_new;
    logic                                      put_head;
    logic                                      consume;
    logic                                      we;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] wdata;
    logic [swstat_pkg::IDX_W-1:0]              rd_addr;
    logic [swstat_pkg::CNT_W-1:0]              mid;
    logic [swstat_pkg::CNT_W-1:0]              head_inc;

    assign active   = busy_reg && !prime_reg;
    assign head_ok  = head_reg < cnt_reg;
    assign skip     = active && rem_reg && head_ok && (q_reg == old_reg);
    assign put_new  = active && !skip && ins_reg && (!head_ok || (q_reg > new_reg));
    assign put_head = active && !skip && !put_new && head_ok;
    assign consume  = skip || put_head;
    assign we       = put_new || put_head;
    assign wdata    = put_new ? new_reg : q_reg;
    assign head_inc = head_reg + 1'b1;
    assign rd_addr  = consume ? head_inc[swstat_pkg::IDX_W-1:0]
                              : head_reg[swstat_pkg::IDX_W-1:0];
    assign mid      = {1'b0, ncnt_reg[swstat_pkg::CNT_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            prime_reg <= 1'b0;
            sel_reg   <= 1'b0;
            ins_reg   <= 1'b0;
            rem_reg   <= 1'b0;
            head_reg  <= '0;
            wr_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            prime_reg <= 1'b1;
            ins_reg   <= 1'b1;
            rem_reg   <= full;
            head_reg  <= '0;
            wr_reg    <= '0;
        end
        else if (prime_reg)
        begin
            prime_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (skip)
            begin
                rem_reg <= 1'b0;
            end
            if (put_new)
            begin
                ins_reg <= 1'b0;
            end
            if (consume)
            begin
                head_reg <= head_inc;
            end
            if (we)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (!we && !skip)
            begin
                // pass finished, the written bank becomes the live copy
                busy_reg <= 1'b0;
                sel_reg  <= !sel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            new_reg  <= new_val;
            old_reg  <= old_val;
            cnt_reg  <= count;
            ncnt_reg <= full ? count : count + 1'b1;
        end
        q_reg <= sel_reg ? bank1[rd_addr] : bank0[rd_addr];
        if (we)
        begin
            if (sel_reg)
            begin
                bank0[wr_reg[swstat_pkg::IDX_W-1:0]] <= wdata;
            end
            else
            begin
                bank1[wr_reg[swstat_pkg::IDX_W-1:0]] <= wdata;
            end
            if (wr_reg == mid)
            begin
                hi_reg <= wdata;
            end
            if (wr_reg == mid - 1'b1)
            begin
                lo_reg <= wdata;
            end
        end
    end

    assign busy      = busy_reg;
    assign median_x2 = ncnt_reg[0] ? {hi_reg, 1'b0}
                                   : 17'(lo_reg) + 17'(hi_reg);

endmodule

// ===== src/swstat_dp.sv =====
// datapath: sample ring, running sums, products, divider, sorter and result register
module swstat_dp (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  swstat_pkg::dp_cmd_t                       cmd,
    output swstat_pkg::dp_sts_t                       sts,
    input  logic                                      func,
    input  logic signed [swstat_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [swstat_pkg::ADDR_W-1:0]             paddr,
    input  logic [swstat_pkg::DATA_W-1:0]             pwdata,
    output logic [swstat_pkg::DATA_W-1:0]             prdata,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [swstat_pkg::MEAN_W-1:0]      mean_q8,
    output logic [swstat_pkg::VAR_W-1:0]              variance_q8,
    output logic signed [swstat_pkg::MED_W-1:0]       median_x2,
    output logic [swstat_pkg::CNT_W-1:0]              fill_count
);

    logic signed [swstat_pkg::SAMPLE_BITS-1:0] ring [swstat_pkg::MAX_WINDOW];

    logic [swstat_pkg::CNT_W-1:0]              window_reg;
    logic [swstat_pkg::CNT_W-1:0]              active_reg;
    logic [swstat_pkg::CNT_W-1:0]              held_reg;
    logic [swstat_pkg::IDX_W-1:0]              widx_reg;
    logic signed [swstat_pkg::SUM_W-1:0]       sum_reg;
    logic [swstat_pkg::SQ_W-1:0]               sq_reg;
    logic                                      full_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] s_reg;
    logic signed [swstat_pkg::SAMPLE_BITS-1:0] old_reg;
    logic [swstat_pkg::PRODA_W-1:0]            proda_reg;
    logic [swstat_pkg::PRODB_W-1:0]            prodb_reg;
    logic [swstat_pkg::DIVS_W-1:0]             den_reg;
    logic [swstat_pkg::MDVD_W-1:0]             mdvd_reg;
    logic                                      neg_reg;
    logic [swstat_pkg::MEAN_W-1:0]             mean_reg;
    logic [swstat_pkg::VAR_W-1:0]              var_reg;
    logic                                      out_valid_reg;
    logic [swstat_pkg::MEAN_W-1:0]             out_mean_reg;
    logic [swstat_pkg::VAR_W-1:0]              out_var_reg;
    logic signed [swstat_pkg::MED_W-1:0]       out_med_reg;
    logic [swstat_pkg::CNT_W-1:0]              out_fill_reg;

    logic signed [swstat_pkg::SSQ_W-1:0]       s_sq;
    logic signed [swstat_pkg::SSQ_W-1:0]       old_sq;
    logic [swstat_pkg::SUM_W-1:0]              sum_abs;
    logic [swstat_pkg::CNT_W:0]                widx_inc;
    logic [2*swstat_pkg::CNT_W-1:0]            den_full;
    logic [swstat_pkg::PRODA_W-1:0]            num_full;
    logic [swstat_pkg::DIVD_W-1:0]             div_dividend;
    logic [swstat_pkg::DIVS_W-1:0]             div_divisor;
    logic [swstat_pkg::DIVD_W-1:0]             quotient;
    logic [swstat_pkg::MEAN_W-1:0]             q_mean;
    logic                                      div_busy;
    logic                                      sort_busy;
    logic signed [swstat_pkg::MED_W-1:0]       sort_med;
    logic                                      cfg_write;
    logic                                      take_clear;

    assign s_sq     = s_reg * s_reg;
    assign old_sq   = old_reg * old_reg;
    assign sum_abs  = sum_reg[swstat_pkg::SUM_W-1] ? 22'(-sum_reg) : 22'(sum_reg);
    assign widx_inc = {2'b00, widx_reg} + 8'd1;
    assign den_full = 14'(held_reg) * 14'(held_reg - 1'b1);
    assign num_full = proda_reg - 45'(prodb_reg);
    assign q_mean   = quotient[swstat_pkg::MEAN_W-1:0];

    assign cfg_write  = psel && penable && pwrite;
    assign take_clear = cmd.take && (func == swstat_pkg::FUNC_CLEAR);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= swstat_pkg::DEFAULT_WINDOW;
        end
        else if (cfg_write && (paddr[2] == swstat_pkg::REG_WINDOW_SIZE))
        begin
            window_reg <= pwdata[swstat_pkg::CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == swstat_pkg::REG_WINDOW_SIZE)
                    ? {25'd0, window_reg} : '0;

    // window state and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= swstat_pkg::DEFAULT_WINDOW;
            held_reg   <= '0;
            widx_reg   <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
        end
        else if (take_clear)
        begin
            if (window_reg == 7'd0)
            begin
                active_reg <= 7'd1;
            end
            else if (window_reg > swstat_pkg::MAX_LEN)
            begin
                active_reg <= swstat_pkg::MAX_LEN;
            end
            else
            begin
                active_reg <= window_reg;
            end
            held_reg <= '0;
            widx_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
        end
        else if (cmd.update)
        begin
            if (!full_reg)
            begin
                held_reg <= held_reg + 1'b1;
                sum_reg  <= sum_reg + 22'(s_reg);
                sq_reg   <= sq_reg + 38'(unsigned'(s_sq));
            end
            else
            begin
                sum_reg <= sum_reg - 22'(old_reg) + 22'(s_reg);
                sq_reg  <= sq_reg - 38'(unsigned'(old_sq)) + 38'(unsigned'(s_sq));
            end
            widx_reg <= (widx_inc == {1'b0, active_reg}) ? '0
                                                         : widx_inc[swstat_pkg::IDX_W-1:0];
        end
    end

    // ring memory, read of the oldest entry and write of the new one share one port
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            s_reg <= sample;
        end
        if (cmd.ring_step)
        begin
            old_reg      <= ring[widx_reg];
            ring[widx_reg] <= s_reg;
            full_reg     <= held_reg >= active_reg;
        end
        if (cmd.mul)
        begin
            proda_reg <= 45'(held_reg) * 45'(sq_reg);
            prodb_reg <= 44'(sum_abs) * 44'(sum_abs);
            den_reg   <= den_full[swstat_pkg::DIVS_W-1:0];
            mdvd_reg  <= {sum_abs, 8'd0};
            neg_reg   <= sum_reg[swstat_pkg::SUM_W-1];
        end
        if (cmd.load_mean)
        begin
            mean_reg <= neg_reg ? -q_mean : q_mean;
        end
        if (cmd.load_var)
        begin
            var_reg <= quotient[swstat_pkg::VAR_W-1:0];
        end
    end

    assign div_dividend = cmd.div_var ? {num_full[swstat_pkg::NUM_W-1:0], 8'd0}
                                      : 51'(mdvd_reg);
    assign div_divisor  = cmd.div_var ? den_reg : 12'(held_reg);

    swstat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_mean || cmd.div_var),
        .long_op  (cmd.div_var),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    swstat_sort u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.update),
        .new_val   (s_reg),
        .old_val   (old_reg),
        .full      (full_reg),
        .count     (held_reg),
        .busy      (sort_busy),
        .median_x2 (sort_med)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_fill_reg <= held_reg;
            out_mean_reg <= (held_reg == 7'd0) ? '0 : mean_reg;
            out_med_reg  <= (held_reg == 7'd0) ? '0 : sort_med;
            out_var_reg  <= (held_reg < 7'd2) ? '0 : var_reg;
        end
    end

    assign sts.func_clear = (func == swstat_pkg::FUNC_CLEAR);
    assign sts.div_busy   = div_busy;
    assign sts.sort_busy  = sort_busy;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign mean_q8     = out_mean_reg;
    assign variance_q8 = out_var_reg;
    assign median_x2   = out_med_reg;
    assign fill_count  = out_fill_reg;

endmodule

// ===== src/swstat_ctrl.sv =====
// controller: sequences ring update, products, divisions and result transfer
module swstat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  swstat_pkg::dp_sts_t sts,
    output swstat_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RING   = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_MEAN   = 4'd4;
    localparam logic [3:0] S_MEAN_W = 4'd5;
    localparam logic [3:0] S_VAR    = 4'd6;
    localparam logic [3:0] S_VAR_W  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = sts.func_clear ? S_DONE : S_RING;
                end
            end
            S_RING:
            begin
                cmd.ring_step = 1'b1;
                state_next    = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                cmd.div_mean = 1'b1;
                state_next   = S_MEAN_W;
            end
            S_MEAN_W:
            begin
                if (!sts.div_busy)
                begin
                    cmd.load_mean = 1'b1;
                    state_next    = S_VAR;
                end
            end
            S_VAR:
            begin
                cmd.div_var = 1'b1;
                state_next  = S_VAR_W;
            end
            S_VAR_W:
            begin
                if (!sts.div_busy)
                begin
                    cmd.load_var = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.sort_busy && sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
